/* src/cpu16_execute_unit_defines.svh */
// ----------------------------------------------------------------------------
// cpu16 execute unit assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CPU16_EXECUTE_UNIT_DEFINES_SVH
`define CPU16_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication
`define CX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpu16 execute unit check failed");

// next-cycle implication
`define CX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpu16 execute unit check failed");

`endif

/* src/cx_pkg.sv */
// ----------------------------------------------------------------------------
// cx_pkg
// opcodes, sub-operations and shared types of the cpu16 execute unit
// ----------------------------------------------------------------------------
package cx_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_AW    = 3;
    localparam logic [REG_AW-1:0] LINK_REG = 3'd7;

    localparam logic [4:0] OP_LOGIC  = 5'd0;
    localparam logic [4:0] OP_SMATH  = 5'd1;
    localparam logic [4:0] OP_UARITH = 5'd2;
    localparam logic [4:0] OP_SHREG  = 5'd3;
    localparam logic [4:0] OP_INCI   = 5'd4;
    localparam logic [4:0] OP_DECI   = 5'd5;
    localparam logic [4:0] OP_ANDI   = 5'd6;
    localparam logic [4:0] OP_ORI    = 5'd7;
    localparam logic [4:0] OP_XORI   = 5'd8;
    localparam logic [4:0] OP_LUI    = 5'd9;
    localparam logic [4:0] OP_SHLI   = 5'd11;
    localparam logic [4:0] OP_SHRI   = 5'd12;
    localparam logic [4:0] OP_SARI   = 5'd13;
    localparam logic [4:0] OP_XSHRI  = 5'd14;
    localparam logic [4:0] OP_BA     = 5'd15;
    localparam logic [4:0] OP_BAL    = 5'd16;
    localparam logic [4:0] OP_BZ     = 5'd17;
    localparam logic [4:0] OP_BNZ    = 5'd18;
    localparam logic [4:0] OP_JR     = 5'd19;
    localparam logic [4:0] OP_JLR    = 5'd20;
    localparam logic [4:0] OP_LDW    = 5'd21;
    localparam logic [4:0] OP_STW    = 5'd22;
    localparam logic [4:0] OP_LL     = 5'd23;
    localparam logic [4:0] OP_SC     = 5'd24;
    localparam logic [4:0] OP_INT    = 5'd27;
    localparam logic [4:0] OP_RFI    = 5'd29;

    localparam logic [1:0] SUB_ADD = 2'd0;
    localparam logic [1:0] SUB_SUB = 2'd1;
    localparam logic [1:0] SUB_MUL = 2'd2;
    localparam logic [1:0] SUB_DIV = 2'd3;

    localparam logic [1:0] LG_OR  = 2'd0;
    localparam logic [1:0] LG_AND = 2'd1;
    localparam logic [1:0] LG_NOR = 2'd2;
    localparam logic [1:0] LG_XOR = 2'd3;

    localparam logic [1:0] SH_SHL  = 2'd0;
    localparam logic [1:0] SH_SHR  = 2'd1;
    localparam logic [1:0] SH_SHRA = 2'd2;
    localparam logic [1:0] SH_WSHR = 2'd3;

    typedef struct packed {
        logic        start;
        logic        is_signed;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;

endpackage

/* src/cx_regfile.sv */
// ----------------------------------------------------------------------------
// cx_regfile
// eight general registers, two registered read ports, one write port
// ----------------------------------------------------------------------------
module cx_regfile (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [cx_pkg::REG_AW-1:0] rd_a_addr,
    input  logic [cx_pkg::REG_AW-1:0] rd_b_addr,
    output logic [15:0]              rd_a_data,
    output logic [15:0]              rd_b_data,
    input  logic                     wr_en,
    input  logic [cx_pkg::REG_AW-1:0] wr_addr,
    input  logic [15:0]              wr_data
);

    logic [15:0]                   regs [cx_pkg::REG_COUNT];
    logic [cx_pkg::REG_COUNT-1:0]  valid_reg;
    logic [15:0]                   rd_a_reg;
    logic [15:0]                   rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            regs[wr_addr] <= wr_data;
        end
        rd_a_reg <= valid_reg[rd_a_addr] ? regs[rd_a_addr] : 16'h0000;
        rd_b_reg <= valid_reg[rd_b_addr] ? regs[rd_b_addr] : 16'h0000;
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

/* src/cx_datamem.sv */
// ----------------------------------------------------------------------------
// cx_datamem
// word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module cx_datamem #(
    parameter int MEM_WORDS = 65536
) (
    input  logic        clk,
    input  logic [15:0] rd_addr,
    output logic [15:0] rd_data,
    input  logic        wr_en,
    input  logic [15:0] wr_addr,
    input  logic [15:0] wr_data
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/cx_divider.sv */
// ----------------------------------------------------------------------------
// cx_divider
// iterative 16-bit divider, one quotient bit a cycle, signed or unsigned
// ----------------------------------------------------------------------------
module cx_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  cx_pkg::div_req_t req,
    output cx_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] dvd_reg;
    logic [15:0] dvs_reg;
    logic [15:0] rem_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        done_reg;
    logic [17:0] diff;
    logic        fits;

    assign diff = {1'b0, rem_reg, dvd_reg[15]} - {2'b00, dvs_reg};
    assign fits = !diff[17];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg   <= (req.is_signed && req.dividend[15]) ? -req.dividend : req.dividend;
            dvs_reg   <= (req.is_signed && req.divisor[15]) ? -req.divisor : req.divisor;
            rem_reg   <= '0;
            neg_q_reg <= req.is_signed && (req.dividend[15] ^ req.divisor[15]);
            neg_r_reg <= req.is_signed && req.dividend[15];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[15:0] : {rem_reg[14:0], dvd_reg[15]};
            dvd_reg <= {dvd_reg[14:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = neg_q_reg ? -dvd_reg : dvd_reg;
    assign rsp.remainder = neg_r_reg ? -rem_reg : rem_reg;

endmodule

/* src/cpu16_execute_unit.sv */
// ----------------------------------------------------------------------------
// cpu16_execute_unit
// execute stage of a 16-bit machine with register file and word memory
// ----------------------------------------------------------------------------
// s_* carries one decoded instruction or one memory preload per item;
// s_tuser selects preload. m_* returns exactly one result per item:
// next pc, register write, memory write, extra register and mode flag.
// the result goes through the register file read on accept, execute and
// commit before it is offered, and the next item can be accepted once it is
// committed. loads add a state for the memory read port, and divides with a
// nonzero divisor add a state that waits for the bit-serial divider.
// s_tready is high only while idle.
// a finished result waits in the output register; if the receiver stalls,
// the next item is still accepted and executed, and holds before commit
// until the output register is free.
// reset clears registers, pc, extra register, link and user flags; the
// word memory is not cleared and a never-written word reads as anything.
// ----------------------------------------------------------------------------
module cpu16_execute_unit #(
    parameter int MEM_WORDS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, subtype, first_arg, second_arg, third_arg, preload_addr,
    // preload_data, zero pad
    input  logic [87:0] s_tdata,
    // operation
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc, halted, reg_written, written_index, written_value,
    // mem_written, mem_address, high_word, in_user_mode, zero pad
    output logic [71:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_MEMRD = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  in_opcode;
    logic [1:0]  in_sub;
    logic [15:0] in_a1, in_a2, in_a3;
    logic        accept;
    logic [2:0]  rd_a_addr, rd_b_addr;

    logic        oper_reg;
    logic [4:0]  op_reg;
    logic [1:0]  sub_reg;
    logic [15:0] a1_reg, a2_reg, a3_reg, paddr_reg, pdata_reg;

    logic [15:0] pc_reg, extra_reg;
    logic        link_reg, user_reg;

    logic        res_wr_reg, res_mw_reg, res_user_reg, res_link_reg;
    logic [2:0]  res_idx_reg;
    logic [15:0] res_val_reg, res_addr_reg, res_mdata_reg, res_pc_reg, res_extra_reg;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    logic [15:0] ra, rb, mem_rd;
    logic        fin_go;

    logic        ex_wr, ex_mw, ex_user, ex_link, ex_load, ex_div;
    logic [2:0]  ex_idx;
    logic [15:0] ex_val, ex_addr, ex_mdata, ex_pc, ex_extra;

    logic        sgn, ex_x, ex_y;
    logic [16:0] sum17;
    logic signed [33:0] prod;
    logic [1:0]  sh_kind;
    logic [15:0] sh_n;
    logic [31:0] sh_wide;
    logic        sh_lo;
    logic [15:0] pc_inc;

    cx_pkg::div_req_t div_req;
    cx_pkg::div_rsp_t div_rsp;

    assign in_opcode = s_tdata[4:0];
    assign in_sub    = s_tdata[6:5];
    assign in_a1     = s_tdata[22:7];
    assign in_a2     = s_tdata[38:23];
    assign in_a3     = s_tdata[54:39];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        rd_a_addr = in_a1[2:0];
        rd_b_addr = in_a3[2:0];
        if (in_opcode inside {cx_pkg::OP_LOGIC, cx_pkg::OP_SMATH, cx_pkg::OP_UARITH,
                              cx_pkg::OP_SHREG, cx_pkg::OP_LDW, cx_pkg::OP_LL})
        begin
            rd_a_addr = in_a2[2:0];
        end
        else if (in_opcode == cx_pkg::OP_RFI)
        begin
            rd_a_addr = cx_pkg::LINK_REG;
        end
        if (in_opcode inside {cx_pkg::OP_STW, cx_pkg::OP_SC})
        begin
            rd_b_addr = in_a2[2:0];
        end
    end

    cx_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (ra),
        .rd_b_data (rb),
        .wr_en     (fin_go && res_wr_reg),
        .wr_addr   (res_idx_reg),
        .wr_data   (res_val_reg)
    );

    cx_datamem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datamem (
        .clk     (clk),
        .rd_addr (ex_addr),
        .rd_data (mem_rd),
        .wr_en   (fin_go && res_mw_reg),
        .wr_addr (res_addr_reg),
        .wr_data (res_mdata_reg)
    );

    assign div_req.start     = (state_reg == ST_EXEC) && ex_div;
    assign div_req.is_signed = (op_reg == cx_pkg::OP_SMATH);
    assign div_req.dividend  = ra;
    assign div_req.divisor   = rb;

    cx_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // arithmetic and shift datapath
    assign sgn    = (op_reg == cx_pkg::OP_SMATH);
    assign ex_x   = sgn & ra[15];
    assign ex_y   = sgn & rb[15];
    assign sum17  = (sub_reg == cx_pkg::SUB_SUB) ? ({ex_x, ra} - {ex_y, rb})
                                                 : ({ex_x, ra} + {ex_y, rb});
    assign prod   = $signed({ex_x, ra}) * $signed({ex_y, rb});
    assign pc_inc = pc_reg + 16'd1;

    always_comb
    begin
        sh_kind = sub_reg;
        sh_n    = rb;
        case (op_reg)
            cx_pkg::OP_SHLI:  sh_kind = cx_pkg::SH_SHL;
            cx_pkg::OP_SHRI:  sh_kind = cx_pkg::SH_SHR;
            cx_pkg::OP_SARI:  sh_kind = cx_pkg::SH_SHRA;
            cx_pkg::OP_XSHRI: sh_kind = cx_pkg::SH_WSHR;
            default:          sh_kind = sub_reg;
        endcase
        if (op_reg != cx_pkg::OP_SHREG)
        begin
            sh_n = {11'd0, a2_reg[4:0]};
        end
        case (sh_kind)
            cx_pkg::SH_SHL:  sh_wide = (|sh_n[15:5]) ? 32'd0 : ({16'd0, ra} << sh_n[4:0]);
            cx_pkg::SH_SHR:  sh_wide = (|sh_n[15:5]) ? 32'd0 : ({ra, 16'd0} >> sh_n[4:0]);
            cx_pkg::SH_SHRA: sh_wide = 32'($signed({ra, 16'd0}) >>> sh_n[4:0]);
            default:         sh_wide = {extra_reg, ra} >> sh_n[4:0];
        endcase
        sh_lo = (sh_kind == cx_pkg::SH_SHL) || (sh_kind == cx_pkg::SH_WSHR);
    end

    always_comb
    begin
        ex_wr    = 1'b0;
        ex_idx   = a1_reg[2:0];
        ex_val   = 16'h0000;
        ex_mw    = 1'b0;
        ex_addr  = 16'h0000;
        ex_mdata = ra;
        ex_pc    = pc_inc;
        ex_extra = extra_reg;
        ex_user  = user_reg;
        ex_link  = link_reg;
        ex_load  = 1'b0;
        ex_div   = 1'b0;
        if (oper_reg)
        begin
            ex_mw    = 1'b1;
            ex_addr  = paddr_reg;
            ex_mdata = pdata_reg;
            ex_pc    = pc_reg;
        end
        else
        begin
            case (op_reg)
                cx_pkg::OP_LOGIC:
                begin
                    ex_wr = 1'b1;
                    case (sub_reg)
                        cx_pkg::LG_OR:  ex_val = ra | rb;
                        cx_pkg::LG_AND: ex_val = ra & rb;
                        cx_pkg::LG_NOR: ex_val = ~(ra | rb);
                        default:        ex_val = ra ^ rb;
                    endcase
                end
                cx_pkg::OP_SMATH, cx_pkg::OP_UARITH:
                begin
                    ex_wr = 1'b1;
                    case (sub_reg)
                        cx_pkg::SUB_MUL:
                        begin
                            ex_val   = prod[15:0];
                            ex_extra = prod[31:16];
                        end
                        cx_pkg::SUB_DIV:
                        begin
                            ex_val   = 16'hFFFF;
                            ex_extra = ra;
                            ex_div   = (rb != 16'h0000);
                        end
                        default:
                        begin
                            ex_val = sum17[15:0];
                            if (!sgn && sub_reg == cx_pkg::SUB_ADD)
                            begin
                                ex_extra = {15'd0, sum17[16]};
                            end
                            else
                            begin
                                ex_extra = {16{sum17[16]}};
                            end
                        end
                    endcase
                end
                cx_pkg::OP_SHREG, cx_pkg::OP_SHLI, cx_pkg::OP_SHRI,
                cx_pkg::OP_SARI, cx_pkg::OP_XSHRI:
                begin
                    ex_wr    = 1'b1;
                    ex_val   = sh_lo ? sh_wide[15:0] : sh_wide[31:16];
                    ex_extra = sh_lo ? sh_wide[31:16] : sh_wide[15:0];
                end
                cx_pkg::OP_INCI: begin ex_wr = 1'b1; ex_val = ra + a2_reg; end
                cx_pkg::OP_DECI: begin ex_wr = 1'b1; ex_val = ra - a2_reg; end
                cx_pkg::OP_ANDI: begin ex_wr = 1'b1; ex_val = ra & a2_reg; end
                cx_pkg::OP_ORI:  begin ex_wr = 1'b1; ex_val = ra | a2_reg; end
                cx_pkg::OP_XORI: begin ex_wr = 1'b1; ex_val = ra ^ a2_reg; end
                cx_pkg::OP_LUI:  begin ex_wr = 1'b1; ex_val = {a2_reg[7:0], 8'd0}; end
                cx_pkg::OP_BA:   ex_pc = pc_reg + a1_reg;
                cx_pkg::OP_BAL:
                begin
                    ex_wr  = 1'b1;
                    ex_idx = cx_pkg::LINK_REG;
                    ex_val = pc_inc;
                    ex_pc  = pc_reg + a1_reg;
                end
                cx_pkg::OP_BZ:   if (ra == 16'h0000) ex_pc = pc_reg + a2_reg;
                cx_pkg::OP_BNZ:  if (ra != 16'h0000) ex_pc = pc_reg + a2_reg;
                cx_pkg::OP_JR:   ex_pc = ra + a2_reg;
                cx_pkg::OP_JLR:
                begin
                    // link goes in first, so a jump through register 7 sees it
                    ex_wr  = 1'b1;
                    ex_idx = cx_pkg::LINK_REG;
                    ex_val = pc_inc;
                    ex_pc  = ((a1_reg[2:0] == cx_pkg::LINK_REG) ? pc_inc : ra) + a2_reg;
                end
                cx_pkg::OP_LDW, cx_pkg::OP_LL:
                begin
                    ex_wr   = 1'b1;
                    ex_addr = ra + a3_reg;
                    ex_load = 1'b1;
                    if (op_reg == cx_pkg::OP_LL)
                    begin
                        ex_link = 1'b1;
                    end
                end
                cx_pkg::OP_STW, cx_pkg::OP_SC:
                begin
                    ex_addr = rb + a3_reg;
                    ex_mw   = (op_reg == cx_pkg::OP_STW) || link_reg;
                    ex_link = 1'b0;
                end
                cx_pkg::OP_INT:
                begin
                    ex_wr   = 1'b1;
                    ex_idx  = cx_pkg::LINK_REG;
                    ex_val  = pc_reg;
                    ex_user = 1'b0;
                end
                cx_pkg::OP_RFI:
                begin
                    ex_pc   = ra;
                    ex_user = 1'b1;
                end
                default:
                begin
                    ex_pc = pc_inc;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (ex_load)
                begin
                    state_next = ST_MEMRD;
                end
                else if (ex_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_MEMRD: state_next = ST_FIN;
            ST_DIV:   if (div_rsp.done) state_next = ST_FIN;
            ST_FIN:   if (fin_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pc_reg       <= '0;
            extra_reg    <= '0;
            link_reg     <= 1'b0;
            user_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                pc_reg       <= res_pc_reg;
                extra_reg    <= res_extra_reg;
                link_reg     <= res_link_reg;
                user_reg     <= res_user_reg;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            oper_reg  <= s_tuser;
            op_reg    <= in_opcode;
            sub_reg   <= in_sub;
            a1_reg    <= in_a1;
            a2_reg    <= in_a2;
            a3_reg    <= in_a3;
            paddr_reg <= s_tdata[70:55];
            pdata_reg <= s_tdata[86:71];
        end
        if (state_reg == ST_EXEC)
        begin
            res_wr_reg    <= ex_wr;
            res_idx_reg   <= ex_wr ? ex_idx : 3'd0;
            res_val_reg   <= ex_val;
            res_mw_reg    <= ex_mw;
            res_addr_reg  <= ex_addr;
            res_mdata_reg <= ex_mdata;
            res_pc_reg    <= ex_pc;
            res_extra_reg <= ex_extra;
            res_user_reg  <= ex_user;
            res_link_reg  <= ex_link;
        end
        if (state_reg == ST_MEMRD)
        begin
            res_val_reg <= mem_rd;
        end
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            res_val_reg   <= div_rsp.quotient;
            res_extra_reg <= div_rsp.remainder;
        end
        if (fin_go)
        begin
            m_tdata_reg <= {1'b0, res_user_reg, res_extra_reg, res_addr_reg, res_mw_reg,
                            res_val_reg, res_idx_reg, res_wr_reg,
                            (res_pc_reg == 16'hFFFF), res_pc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/cx_checker.sv */
// ----------------------------------------------------------------------------
// cx_checker
// port-level checks of the cpu16 execute unit, bound to the top level
// ----------------------------------------------------------------------------
`include "cpu16_execute_unit_defines.svh"

module cx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    `CX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CX_ASSERT_NOW(a_halt_flag, m_tvalid, m_tdata[16] == (m_tdata[15:0] == 16'hFFFF))
    `CX_ASSERT_NOW(a_no_write_zero, m_tvalid && !m_tdata[17], m_tdata[36:18] == 19'd0)
    `CX_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

endmodule

bind cpu16_execute_unit cx_checker u_cx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for cpu16_execute_unit: a directed table of items, then
// random instruction streams; each result is compared with its fixed table entry or
// an in-bench model of the register file, pc, extra register, flags and word memory
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] OP_LDCP = 5'd25;
    localparam logic [4:0] OP_STCP = 5'd26;
    localparam int RANDOM_ITEMS = 1820;

    typedef struct packed {
        logic        preload;
        logic [4:0]  opc;
        logic [1:0]  sub;
        logic [15:0] a1;
        logic [15:0] a2;
        logic [15:0] a3;
        logic [15:0] paddr;
        logic [15:0] pdata;
    } instr_t;

    // lowest field last, to line up with m_tdata
    typedef struct packed {
        logic        in_user_mode;
        logic [15:0] high_word;
        logic [15:0] mem_address;
        logic        mem_written;
        logic [15:0] written_value;
        logic [2:0]  written_index;
        logic        reg_written;
        logic        halted;
        logic [15:0] next_pc;
    } result_t;

    typedef struct packed {
        instr_t  item;
        logic    fixed;
        result_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    logic [15:0] regs [cx_pkg::REG_COUNT];
    logic [15:0] pc_q;
    logic [15:0] extra_q;
    logic        link_q;
    logic        user_q;
    logic [15:0] mem_words [int];
    logic [15:0] written_addrs [$];
    logic        wr_f;
    logic [2:0]  wr_i;
    logic [15:0] wr_v;

    result_t     pending [$];
    row_t        rows [$];
    int          errors;
    int          idle_pct;
    int          stall_pct;

    cpu16_execute_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void put_reg(logic [2:0] idx, logic [15:0] val);
        regs[idx] = val;
        wr_f = 1'b1;
        wr_i = idx;
        wr_v = val;
    endfunction

    function automatic void mem_write(logic [15:0] addr, logic [15:0] val);
        if (!mem_words.exists(addr))
            written_addrs.push_back(addr);
        mem_words[addr] = val;
    endfunction

    function automatic result_t execute_item(instr_t it);
        result_t     r;
        logic [15:0] nxt;
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] ma;
        logic [31:0] u;
        logic [4:0]  n;
        int          x;
        int          y;
        int          z;
        logic        mw;
        nxt = pc_q + 16'd1;
        ma = '0;
        mw = 1'b0;
        wr_f = 1'b0;
        wr_i = '0;
        wr_v = '0;
        ux = regs[it.a2[2:0]];
        uy = regs[it.a3[2:0]];
        x = $signed(ux);
        y = $signed(uy);
        n = it.a2[4:0];
        if (it.preload)
        begin
            ma = it.paddr;
            mem_write(ma, it.pdata);
            mw = 1'b1;
            nxt = pc_q;
        end
        else
        begin
            case (it.opc)
                cx_pkg::OP_LOGIC:
                    case (it.sub)
                        cx_pkg::LG_OR:  put_reg(it.a1[2:0], ux | uy);
                        cx_pkg::LG_AND: put_reg(it.a1[2:0], ux & uy);
                        cx_pkg::LG_NOR: put_reg(it.a1[2:0], ~(ux | uy));
                        default:        put_reg(it.a1[2:0], ux ^ uy);
                    endcase
                cx_pkg::OP_SMATH:
                begin
                    if (it.sub == cx_pkg::SUB_DIV)
                    begin
                        if (y == 0)
                        begin
                            z = 32'hFFFF;
                            extra_q = ux;
                        end
                        else
                        begin
                            z = x / y;
                            u = x % y;
                            extra_q = u[15:0];
                        end
                    end
                    else
                    begin
                        if (it.sub == cx_pkg::SUB_ADD)
                            z = x + y;
                        else if (it.sub == cx_pkg::SUB_SUB)
                            z = x - y;
                        else
                            z = x * y;
                        u = z;
                        extra_q = u[31:16];
                    end
                    u = z;
                    put_reg(it.a1[2:0], u[15:0]);
                end
                cx_pkg::OP_UARITH:
                begin
                    if (it.sub == cx_pkg::SUB_DIV)
                    begin
                        if (uy == 0)
                        begin
                            u = 32'hFFFF;
                            extra_q = ux;
                        end
                        else
                        begin
                            u = {16'd0, ux} / {16'd0, uy};
                            extra_q = ux % uy;
                        end
                    end
                    else
                    begin
                        if (it.sub == cx_pkg::SUB_ADD)
                            u = {16'd0, ux} + {16'd0, uy};
                        else if (it.sub == cx_pkg::SUB_SUB)
                            u = {16'd0, ux} - {16'd0, uy};
                        else
                            u = {16'd0, ux} * {16'd0, uy};
                        extra_q = u[31:16];
                    end
                    put_reg(it.a1[2:0], u[15:0]);
                end
                cx_pkg::OP_SHREG:
                begin
                    case (it.sub)
                        cx_pkg::SH_SHL:  u = (uy >= 32) ? 32'd0 : ({16'd0, ux} << uy);
                        cx_pkg::SH_SHR:  u = (uy >= 32) ? 32'd0 : ({ux, 16'd0} >> uy);
                        cx_pkg::SH_SHRA: u = $signed({ux, 16'd0}) >>> uy[4:0];
                        default:         u = {extra_q, ux} >> uy[4:0];
                    endcase
                    if (it.sub == cx_pkg::SH_SHL || it.sub == cx_pkg::SH_WSHR)
                    begin
                        put_reg(it.a1[2:0], u[15:0]);
                        extra_q = u[31:16];
                    end
                    else
                    begin
                        put_reg(it.a1[2:0], u[31:16]);
                        extra_q = u[15:0];
                    end
                end
                cx_pkg::OP_INCI: put_reg(it.a1[2:0], regs[it.a1[2:0]] + it.a2);
                cx_pkg::OP_DECI: put_reg(it.a1[2:0], regs[it.a1[2:0]] - it.a2);
                cx_pkg::OP_ANDI: put_reg(it.a1[2:0], regs[it.a1[2:0]] & it.a2);
                cx_pkg::OP_ORI:  put_reg(it.a1[2:0], regs[it.a1[2:0]] | it.a2);
                cx_pkg::OP_XORI: put_reg(it.a1[2:0], regs[it.a1[2:0]] ^ it.a2);
                cx_pkg::OP_LUI:  put_reg(it.a1[2:0], {it.a2[7:0], 8'h00});
                cx_pkg::OP_SHLI, cx_pkg::OP_XSHRI:
                begin
                    if (it.opc == cx_pkg::OP_SHLI)
                        u = {16'd0, regs[it.a1[2:0]]} << n;
                    else
                        u = {extra_q, regs[it.a1[2:0]]} >> n;
                    put_reg(it.a1[2:0], u[15:0]);
                    extra_q = u[31:16];
                end
                cx_pkg::OP_SHRI, cx_pkg::OP_SARI:
                begin
                    if (it.opc == cx_pkg::OP_SHRI)
                        u = {regs[it.a1[2:0]], 16'd0} >> n;
                    else
                        u = $signed({regs[it.a1[2:0]], 16'd0}) >>> n;
                    put_reg(it.a1[2:0], u[31:16]);
                    extra_q = u[15:0];
                end
                cx_pkg::OP_BA: nxt = pc_q + it.a1;
                cx_pkg::OP_BAL:
                begin
                    put_reg(cx_pkg::LINK_REG, pc_q + 16'd1);
                    nxt = pc_q + it.a1;
                end
                cx_pkg::OP_BZ:  if (regs[it.a1[2:0]] == 16'd0) nxt = pc_q + it.a2;
                cx_pkg::OP_BNZ: if (regs[it.a1[2:0]] != 16'd0) nxt = pc_q + it.a2;
                cx_pkg::OP_JR:  nxt = regs[it.a1[2:0]] + it.a2;
                cx_pkg::OP_JLR:
                begin
                    put_reg(cx_pkg::LINK_REG, pc_q + 16'd1);
                    nxt = regs[it.a1[2:0]] + it.a2;
                end
                cx_pkg::OP_LDW, cx_pkg::OP_LL:
                begin
                    ma = ux + it.a3;
                    if (it.opc == cx_pkg::OP_LL)
                        link_q = 1'b1;
                    put_reg(it.a1[2:0], mem_words.exists(ma) ? mem_words[ma] : 16'd0);
                end
                cx_pkg::OP_STW, cx_pkg::OP_SC:
                begin
                    ma = ux + it.a3;
                    if (it.opc == cx_pkg::OP_STW || link_q)
                    begin
                        mem_write(ma, regs[it.a1[2:0]]);
                        mw = 1'b1;
                    end
                    link_q = 1'b0;
                end
                cx_pkg::OP_INT:
                begin
                    put_reg(cx_pkg::LINK_REG, pc_q);
                    user_q = 1'b0;
                end
                cx_pkg::OP_RFI:
                begin
                    nxt = regs[cx_pkg::LINK_REG];
                    user_q = 1'b1;
                end
                default: ;
            endcase
        end
        pc_q = nxt;
        r.next_pc = nxt;
        r.halted = (nxt == 16'hFFFF);
        r.reg_written = wr_f;
        r.written_index = wr_i;
        r.written_value = wr_v;
        r.mem_written = mw;
        r.mem_address = ma;
        r.high_word = extra_q;
        r.in_user_mode = user_q;
        return r;
    endfunction

    function automatic instr_t mk(logic pl, logic [4:0] opc, logic [1:0] sub,
                                  logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
        instr_t it;
        it = '0;
        it.preload = pl;
        it.opc = opc;
        it.sub = sub;
        it.a1 = a1;
        it.a2 = a2;
        it.a3 = a3;
        return it;
    endfunction

    function automatic void add_row(instr_t it);
        row_t rw;
        rw = '0;
        rw.item = it;
        rows.push_back(rw);
    endfunction

    function automatic void add_fixed(instr_t it, result_t want);
        row_t rw;
        rw.item = it;
        rw.fixed = 1'b1;
        rw.want = want;
        rows.push_back(rw);
    endfunction

    function automatic void build_table();
        instr_t  it;
        result_t w;
        // preload at both address extremes, data extremes
        it = mk(1'b1, cx_pkg::OP_LOGIC, 2'd0, 16'd0, 16'd0, 16'd0);
        it.paddr = 16'h0000;
        it.pdata = 16'hFFFF;
        w = '0;
        w.mem_written = 1'b1;
        add_fixed(it, w);
        it.paddr = 16'hFFFF;
        it.pdata = 16'h8000;
        w.mem_address = 16'hFFFF;
        add_fixed(it, w);
        w = '0;
        w.next_pc = 16'd1;
        w.reg_written = 1'b1;
        w.written_index = 3'd1;
        w.written_value = 16'd1;
        add_fixed(mk(1'b0, cx_pkg::OP_INCI, 2'd0, 16'd1, 16'd1, 16'd0), w);
        w.next_pc = 16'd2;
        w.written_index = 3'd2;
        w.written_value = 16'hFFFF;
        add_fixed(mk(1'b0, cx_pkg::OP_DECI, 2'd0, 16'hFFFA, 16'd1, 16'd0), w);
        add_row(mk(1'b0, cx_pkg::OP_LUI, 2'd0, 16'd3, 16'hFF80, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_SMATH, cx_pkg::SUB_DIV, 16'd4, 16'd3, 16'd5));
        add_row(mk(1'b0, cx_pkg::OP_DECI, 2'd0, 16'd6, 16'd1, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_SMATH, cx_pkg::SUB_DIV, 16'd4, 16'd3, 16'd6));
        add_row(mk(1'b0, cx_pkg::OP_SMATH, cx_pkg::SUB_MUL, 16'd5, 16'd3, 16'd3));
        add_row(mk(1'b0, cx_pkg::OP_UARITH, cx_pkg::SUB_MUL, 16'd5, 16'd2, 16'd2));
        add_row(mk(1'b0, cx_pkg::OP_UARITH, cx_pkg::SUB_DIV, 16'd5, 16'd2, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_SHREG, cx_pkg::SH_SHL, 16'd5, 16'd2, 16'd2));
        add_row(mk(1'b0, cx_pkg::OP_SHREG, cx_pkg::SH_SHR, 16'd5, 16'd2, 16'd2));
        add_row(mk(1'b0, cx_pkg::OP_SHREG, cx_pkg::SH_SHRA, 16'd5, 16'd3, 16'd6));
        add_row(mk(1'b0, cx_pkg::OP_SHREG, cx_pkg::SH_WSHR, 16'd5, 16'd2, 16'd6));
        add_row(mk(1'b0, cx_pkg::OP_SARI, 2'd0, 16'd3, 16'hFFFF, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_LOGIC, cx_pkg::LG_NOR, 16'd5, 16'd0, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_LDW, 2'd0, 16'd5, 16'd0, 16'hFFFF));
        add_row(mk(1'b0, cx_pkg::OP_LL, 2'd0, 16'd5, 16'd0, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_SC, 2'd0, 16'd2, 16'd0, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_SC, 2'd0, 16'd1, 16'd0, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_BZ, 2'd0, 16'd0, 16'h7FFF, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_JLR, 2'd0, 16'd7, 16'h8000, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_INT, 2'd0, 16'd0, 16'd0, 16'd0));
        add_row(mk(1'b0, cx_pkg::OP_RFI, 2'd0, 16'd0, 16'd0, 16'd0));
        add_row(mk(1'b0, 5'd31, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endfunction

    function automatic instr_t random_item();
        instr_t it;
        int     pick;
        it.preload = 1'b0;
        it.opc = 5'($urandom_range(0, 31));
        it.sub = 2'($urandom);
        it.a1 = 16'($urandom);
        it.a2 = 16'($urandom);
        it.a3 = 16'($urandom);
        it.paddr = 16'($urandom);
        it.pdata = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12 || written_addrs.size() == 0)
        begin
            it.preload = 1'b1;
            if ($urandom_range(0, 3) == 0)
                it.paddr = {12'd0, it.paddr[3:0]};
        end
        else if (pick < 25)
        begin
            it.opc = ($urandom_range(0, 1) == 0) ? cx_pkg::OP_LDW : cx_pkg::OP_LL;
        end
        else if (pick < 30)
        begin
            it.opc = cx_pkg::OP_SC;
        end
        if (!it.preload && (it.opc == OP_LDCP || it.opc == OP_STCP) && $urandom_range(0, 1))
            it.opc = cx_pkg::OP_INCI;
        // loads only touch words already written
        if (!it.preload && (it.opc == cx_pkg::OP_LDW || it.opc == cx_pkg::OP_LL))
            it.a3 = written_addrs[$urandom_range(0, written_addrs.size() - 1)]
                    - regs[it.a2[2:0]];
        return it;
    endfunction

    task automatic send_item(instr_t it, logic fixed, result_t want);
        result_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = it.preload;
        s_tdata = {1'b0, it.pdata, it.paddr, it.a3, it.a2, it.a1, it.sub, it.opc};
        do
            @(posedge clk);
        while (!s_tready);
        r = execute_item(it);
        pending.push_back(fixed ? want : r);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        else
            m_tready = 1'b0;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[70:0];
            if (pending.size() == 0)
            begin
                report("unexpected item", got.next_pc, 16'd0);
            end
            else
            begin
                exp_r = pending.pop_front();
                if (got.next_pc !== exp_r.next_pc)
                    report("next_pc", got.next_pc, exp_r.next_pc);
                if (got.halted !== exp_r.halted)
                    report("halted", got.halted, exp_r.halted);
                if (got.reg_written !== exp_r.reg_written)
                    report("reg_written", got.reg_written, exp_r.reg_written);
                if (got.written_index !== exp_r.written_index)
                    report("written_index", got.written_index, exp_r.written_index);
                if (got.written_value !== exp_r.written_value)
                    report("written_value", got.written_value, exp_r.written_value);
                if (got.mem_written !== exp_r.mem_written)
                    report("mem_written", got.mem_written, exp_r.mem_written);
                if (got.mem_address !== exp_r.mem_address)
                    report("mem_address", got.mem_address, exp_r.mem_address);
                if (got.high_word !== exp_r.high_word)
                    report("high_word", got.high_word, exp_r.high_word);
                if (got.in_user_mode !== exp_r.in_user_mode)
                    report("in_user_mode", got.in_user_mode, exp_r.in_user_mode);
            end
        end
    end

    initial
    begin
        #10ms;
        $display("cpu16_execute_unit test failed");
        $finish;
    end

    initial
    begin
        int      phase;
        int      k;
        instr_t  it;
        result_t none;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        none = '0;
        foreach (regs[i])
            regs[i] = '0;
        pc_q = '0;
        extra_q = '0;
        link_q = 1'b0;
        user_q = 1'b0;
        build_table();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i])
            send_item(rows[i].item, rows[i].fixed, rows[i].want);
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            // hold off until the block has drained
            if (phase == 2)
                while (pending.size() != 0)
                    @(negedge clk);
            for (k = 0; k < RANDOM_ITEMS / 4; k++)
            begin
                it = random_item();
                send_item(it, 1'b0, none);
            end
        end
        while (pending.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (errors == 0)
            $display("cpu16_execute_unit test passed");
        else
            $display("cpu16_execute_unit test failed");
        $finish;
    end
endmodule
